@@ hdl/ubxfr_pkg.sv @@
// Package for the UBX frame receiver: status codes, parser phases and
// protocol constants. No dependencies.
package ubxfr_pkg;

    typedef enum logic [3:0] {
        ST_WAIT      = 4'd0,
        ST_TOO_LONG  = 4'd1,
        ST_BAD_SUM   = 4'd2,
        ST_ACK       = 4'd3,
        ST_NAK       = 4'd4,
        ST_PVT       = 4'd5,
        ST_TIMELS    = 4'd6,
        ST_TIM_TP    = 4'd7,
        ST_CFG_NAV5  = 4'd8,
        ST_UNHANDLED = 4'd9
    } t_status;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_SYNC1     = 8'b0000_0010,
        PH_CLASS     = 8'b0000_0100,
        PH_ID        = 8'b0000_1000,
        PH_LEN_LO    = 8'b0001_0000,
        PH_LEN_HI    = 8'b0010_0000,
        PH_PAYLOAD   = 8'b0100_0000,
        PH_TRAILER_B = 8'b1000_0000
    } t_phase;

    typedef enum logic [1:0] {
        CFG_LENGTH_LIMIT = 2'd0,
        CFG_EXP_DYN      = 2'd1,
        CFG_EXP_UTC      = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_index;

    localparam logic [7:0] SYNC_FIRST    = 8'hB5;
    localparam logic [7:0] SYNC_SECOND   = 8'h62;
    localparam logic [7:0] CLS_NAV       = 8'h01;
    localparam logic [7:0] CLS_ACK       = 8'h05;
    localparam logic [7:0] CLS_CFG       = 8'h06;
    localparam logic [7:0] CLS_TIM       = 8'h0D;
    localparam logic [7:0] ID_ACK_NAK    = 8'h00;
    localparam logic [7:0] ID_ACK_ACK    = 8'h01;
    localparam logic [7:0] ID_NAV_PVT    = 8'h07;
    localparam logic [7:0] ID_NAV_TIMELS = 8'h26;
    localparam logic [7:0] ID_TIM_TP     = 8'h01;
    localparam logic [7:0] ID_CFG_NAV5   = 8'h24;

    localparam logic [7:0] TP_FLAG_UTC_BASE  = 8'h01;
    localparam logic [7:0] TP_FLAG_UTC_AVAIL = 8'h02;
    localparam logic [7:0] TP_REF_UTC_MASK   = 8'h30;

    localparam logic [15:0] RST_LENGTH_LIMIT = 16'd128;
    localparam logic [7:0]  RST_EXP_DYN      = 8'd2;
    localparam logic [7:0]  RST_EXP_UTC      = 8'd3;

    // payload offsets of captured fields
    localparam logic [15:0] OFF_TOW_MS0 = 16'd0;
    localparam logic [15:0] OFF_TOW_MS1 = 16'd1;
    localparam logic [15:0] OFF_TOW_MS2 = 16'd2;
    localparam logic [15:0] OFF_TOW_MS3 = 16'd3;
    localparam logic [15:0] OFF_SUB0    = 16'd4;
    localparam logic [15:0] OFF_SUB1    = 16'd5;
    localparam logic [15:0] OFF_SUB2    = 16'd6;
    localparam logic [15:0] OFF_SUB3    = 16'd7;
    localparam logic [15:0] OFF_WEEK_LO = 16'd12;
    localparam logic [15:0] OFF_WEEK_HI = 16'd13;
    localparam logic [15:0] OFF_FLAGS   = 16'd14;
    localparam logic [15:0] OFF_REF     = 16'd15;
    localparam logic [15:0] OFF_DYN     = 16'd2;
    localparam logic [15:0] OFF_UTC     = 16'd30;

endpackage

@@ hdl/ubx_frame_receiver_core.sv @@
// UBX frame receiver top level: sync hunt, header, payload capture,
// Fletcher-16 check (two 8-bit sums) and frame classification. Depends on ubxfr_pkg.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_rx_byte
//  out     | output    | o_out_valid / i_out_stall | o_status, o_frame_class, o_frame_id,
//          |           |                        | o_pulse_*, o_model_mismatch, o_utc_mismatch
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One byte per cycle unless a held result stalls the input: each byte goes through the parser
//  logic in the cycle it is accepted and its result lands in the output register at that edge.
//  A byte is accepted whenever the output register is empty or being taken,
//  so a stalled result stalls the input side only while it is held.
//  Synchronous active-low reset puts the parser in sync hunt, clears all
//  held pulse time and loads the register defaults. No clearing pass.
module ubx_frame_receiver_core
    import ubxfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_status,
    output logic [7:0]  o_frame_class,
    output logic [7:0]  o_frame_id,
    output logic        o_pulse_time_valid,
    output logic [15:0] o_pulse_week,
    output logic [63:0] o_pulse_tow,
    output logic        o_model_mismatch,
    output logic        o_utc_mismatch,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration registers
    logic [15:0] r_length_limit;
    logic [7:0]  r_exp_dyn;
    logic [7:0]  r_exp_utc;

    // parser state
    t_phase      r_phase,      n_phase;
    logic [7:0]  r_cls,        n_cls;
    logic [7:0]  r_id,         n_id;
    logic [15:0] r_len,        n_len;
    logic [15:0] r_left,       n_left;
    logic [15:0] r_offset,     n_offset;
    logic [7:0]  r_sum_a,      n_sum_a;
    logic [7:0]  r_sum_b,      n_sum_b;
    logic [7:0]  r_trl_a,      n_trl_a;

    // per-frame captures
    logic [31:0] r_cap_ms,     n_cap_ms;
    logic [31:0] r_cap_sub,    n_cap_sub;
    logic [15:0] r_cap_week,   n_cap_week;
    logic [7:0]  r_cap_flags,  n_cap_flags;
    logic [7:0]  r_cap_ref,    n_cap_ref;
    logic [7:0]  r_cap_dyn,    n_cap_dyn;
    logic [7:0]  r_cap_utc,    n_cap_utc;

    // held pulse time; only moves on an accepted byte, so it is the
    // payload of the result in the output register
    logic        r_held_valid, n_held_valid;
    logic [15:0] r_held_week,  n_held_week;
    logic [63:0] r_held_tow,   n_held_tow;

    // output register
    logic        r_out_valid;
    t_status     r_out_status, n_status;
    logic [7:0]  r_out_cls,    n_fc;
    logic [7:0]  r_out_id,     n_fi;
    logic        r_out_mm,     n_mm;
    logic        r_out_um,     n_um;

    logic        in_accept;
    logic        out_take;
    logic [15:0] full_len;
    logic        sum_ok;
    logic        tp_good;

    assign o_cfg_ready = 1'b1;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;

    assign full_len = {i_rx_byte, r_len[7:0]};
    assign sum_ok   = (r_trl_a == r_sum_a) && (i_rx_byte == r_sum_b);
    assign tp_good  = ((r_cap_flags & TP_FLAG_UTC_BASE) != 8'd0)
                   && ((r_cap_flags & TP_FLAG_UTC_AVAIL) != 8'd0)
                   && ((r_cap_ref & TP_REF_UTC_MASK) != 8'd0);

    always_comb begin
        n_phase      = r_phase;
        n_cls        = r_cls;
        n_id         = r_id;
        n_len        = r_len;
        n_left       = r_left;
        n_offset     = r_offset;
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_trl_a      = r_trl_a;
        n_cap_ms     = r_cap_ms;
        n_cap_sub    = r_cap_sub;
        n_cap_week   = r_cap_week;
        n_cap_flags  = r_cap_flags;
        n_cap_ref    = r_cap_ref;
        n_cap_dyn    = r_cap_dyn;
        n_cap_utc    = r_cap_utc;
        n_held_valid = r_held_valid;
        n_held_week  = r_held_week;
        n_held_tow   = r_held_tow;
        n_status     = ST_WAIT;
        n_fc         = 8'd0;
        n_fi         = 8'd0;
        n_mm         = 1'b0;
        n_um         = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_rx_byte == SYNC_FIRST) n_phase = PH_SYNC1;
            end
            PH_SYNC1: begin
                n_phase = (i_rx_byte == SYNC_SECOND) ? PH_CLASS : PH_IDLE;
            end
            PH_CLASS: begin
                // frame start: sum restarts, captures clear
                n_sum_a     = i_rx_byte;
                n_sum_b     = i_rx_byte;
                n_cap_ms    = '0;
                n_cap_sub   = '0;
                n_cap_week  = '0;
                n_cap_flags = '0;
                n_cap_ref   = '0;
                n_cap_dyn   = '0;
                n_cap_utc   = '0;
                n_cls       = i_rx_byte;
                n_phase     = PH_ID;
            end
            PH_ID: begin
                n_sum_a = r_sum_a + i_rx_byte;
                n_sum_b = r_sum_b + n_sum_a;
                n_id    = i_rx_byte;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_sum_a = r_sum_a + i_rx_byte;
                n_sum_b = r_sum_b + n_sum_a;
                n_len   = {8'd0, i_rx_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_sum_a = r_sum_a + i_rx_byte;
                n_sum_b = r_sum_b + n_sum_a;
                n_len   = full_len;
                if (full_len >= r_length_limit) begin
                    n_status = ST_TOO_LONG;
                    n_fc     = r_cls;
                    n_fi     = r_id;
                    n_phase  = PH_IDLE;
                end else begin
                    n_left   = full_len;
                    n_offset = '0;
                    n_phase  = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (r_left != 16'd0) begin
                    n_sum_a  = r_sum_a + i_rx_byte;
                    n_sum_b  = r_sum_b + n_sum_a;
                    n_left   = r_left - 16'd1;
                    n_offset = r_offset + 16'd1;
                    // each offset comes once per frame, so plain loads
                    unique case (r_offset)
                        OFF_TOW_MS0: n_cap_ms[7:0]    = i_rx_byte;
                        OFF_TOW_MS1: n_cap_ms[15:8]   = i_rx_byte;
                        OFF_TOW_MS2: n_cap_ms[23:16]  = i_rx_byte;
                        OFF_TOW_MS3: n_cap_ms[31:24]  = i_rx_byte;
                        OFF_SUB0:    n_cap_sub[7:0]   = i_rx_byte;
                        OFF_SUB1:    n_cap_sub[15:8]  = i_rx_byte;
                        OFF_SUB2:    n_cap_sub[23:16] = i_rx_byte;
                        OFF_SUB3:    n_cap_sub[31:24] = i_rx_byte;
                        OFF_WEEK_LO: n_cap_week[7:0]  = i_rx_byte;
                        OFF_WEEK_HI: n_cap_week[15:8] = i_rx_byte;
                        OFF_FLAGS:   n_cap_flags      = i_rx_byte;
                        OFF_REF:     n_cap_ref        = i_rx_byte;
                        default: ;
                    endcase
                    if (r_offset == OFF_DYN) n_cap_dyn = i_rx_byte;
                    if (r_offset == OFF_UTC) n_cap_utc = i_rx_byte;
                end else begin
                    n_trl_a = i_rx_byte;
                    n_phase = PH_TRAILER_B;
                end
            end
            PH_TRAILER_B: begin
                n_phase = PH_IDLE;
                n_fc    = r_cls;
                n_fi    = r_id;
                priority if (!sum_ok) begin
                    n_status = ST_BAD_SUM;
                end else if (r_cls == CLS_ACK) begin
                    n_status = (r_id == ID_ACK_ACK) ? ST_ACK :
                               (r_id == ID_ACK_NAK) ? ST_NAK : ST_UNHANDLED;
                end else if (r_cls == CLS_NAV) begin
                    n_status = (r_id == ID_NAV_PVT)    ? ST_PVT :
                               (r_id == ID_NAV_TIMELS) ? ST_TIMELS : ST_UNHANDLED;
                end else if (r_cls == CLS_TIM) begin
                    if (r_id == ID_TIM_TP) begin
                        n_status = ST_TIM_TP;
                        if (tp_good) begin
                            n_held_week  = r_cap_week;
                            n_held_tow   = {r_cap_ms, r_cap_sub};
                            n_held_valid = 1'b1;
                        end else begin
                            n_held_valid = 1'b0;
                        end
                    end else begin
                        n_status = ST_UNHANDLED;
                    end
                end else if (r_cls == CLS_CFG) begin
                    if (r_id == ID_CFG_NAV5) begin
                        n_status = ST_CFG_NAV5;
                        n_mm     = (r_cap_dyn != r_exp_dyn);
                        n_um     = (r_cap_utc != r_exp_utc);
                    end else begin
                        n_status = ST_UNHANDLED;
                    end
                end else begin
                    // unknown class: wait, class and id still reported
                    n_status = ST_WAIT;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // configuration port; index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_limit <= RST_LENGTH_LIMIT;
            r_exp_dyn      <= RST_EXP_DYN;
            r_exp_utc      <= RST_EXP_UTC;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LENGTH_LIMIT: r_length_limit <= i_cfg_data;
                CFG_EXP_DYN:      r_exp_dyn      <= i_cfg_data[7:0];
                CFG_EXP_UTC:      r_exp_utc      <= i_cfg_data[7:0];
                CFG_UNUSED:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_cls        <= '0;
            r_id         <= '0;
            r_len        <= '0;
            r_left       <= '0;
            r_offset     <= '0;
            r_sum_a      <= '0;
            r_sum_b      <= '0;
            r_trl_a      <= '0;
            r_cap_ms     <= '0;
            r_cap_sub    <= '0;
            r_cap_week   <= '0;
            r_cap_flags  <= '0;
            r_cap_ref    <= '0;
            r_cap_dyn    <= '0;
            r_cap_utc    <= '0;
            r_held_valid <= 1'b0;
            r_held_week  <= '0;
            r_held_tow   <= '0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_cls        <= n_cls;
            r_id         <= n_id;
            r_len        <= n_len;
            r_left       <= n_left;
            r_offset     <= n_offset;
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
            r_trl_a      <= n_trl_a;
            r_cap_ms     <= n_cap_ms;
            r_cap_sub    <= n_cap_sub;
            r_cap_week   <= n_cap_week;
            r_cap_flags  <= n_cap_flags;
            r_cap_ref    <= n_cap_ref;
            r_cap_dyn    <= n_cap_dyn;
            r_cap_utc    <= n_cap_utc;
            r_held_valid <= n_held_valid;
            r_held_week  <= n_held_week;
            r_held_tow   <= n_held_tow;
        end
    end

    // result register: one result per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_status <= n_status;
            r_out_cls    <= n_fc;
            r_out_id     <= n_fi;
            r_out_mm     <= n_mm;
            r_out_um     <= n_um;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_frame_class      = r_out_cls;
    assign o_frame_id         = r_out_id;
    assign o_pulse_time_valid = r_held_valid;
    assign o_pulse_week       = r_held_week;
    assign o_pulse_tow        = r_held_tow;
    assign o_model_mismatch   = r_out_mm;
    assign o_utc_mismatch     = r_out_um;

    // mismatch flags only ride on a CFG-NAV5 result
    a_mismatch_only_nav5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_mm || r_out_um)) |-> (r_out_status == ST_CFG_NAV5))
        else $error("mismatch flag on a non CFG-NAV5 result");

    // pulse time becomes valid only together with a TIM-TP result
    a_valid_from_tim_tp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_held_valid) |-> (r_out_valid && r_out_status == ST_TIM_TP))
        else $error("pulse time valid without TIM-TP");

    // an over-length header sends the parser back to sync hunt
    a_too_long_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_LEN_HI && full_len >= r_length_limit)
        |=> (r_phase == PH_IDLE && r_out_status == ST_TOO_LONG))
        else $error("length rejection did not return to hunt");

    // payload position bookkeeping stays consistent
    a_offset_tracks_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_offset + r_left == r_len))
        else $error("payload offset and remaining count disagree");

    // results are only replaced after being taken or when none is held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !in_accept)
        else $error("held result overwritten");

endmodule
